### design/ilir_pkg.sv
`timescale 1ns / 1ps
// Shared sizes, codes and the command type for the indexed list.
// No dependencies; used by every module of the block.
package ilir_pkg;

  localparam int CAPACITY   = 64;
  localparam int ELEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = (CNT_W > 8) ? CNT_W : 8;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  typedef logic [ELEM_WIDTH-1:0] elem_t;

  typedef struct packed {
    logic             insert;
    logic             remove;
    logic [IDX_W-1:0] at;
    elem_t            value;
  } cmd_t;

endpackage

### design/ilir_cell.sv
`timescale 1ns / 1ps
// One list slot: holds an entry, opens or closes the gap at the command position.
// Depends on ilir_pkg for the command type and sizes.
module ilir_cell (
  input  logic                      clk_i,
  input  logic [ilir_pkg::IDX_W-1:0] idx_i,
  input  ilir_pkg::cmd_t            cmd_i,
  input  ilir_pkg::elem_t           lower_i,
  input  ilir_pkg::elem_t           upper_i,
  output ilir_pkg::elem_t           data_o
);

  ilir_pkg::elem_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.insert) begin
      if (idx_i > cmd_i.at) begin
        data_d = lower_i;
      end else if (idx_i == cmd_i.at) begin
        data_d = cmd_i.value;
      end
    end else if (cmd_i.remove) begin
      if (idx_i >= cmd_i.at) begin
        data_d = upper_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### design/indexed_list_insert_remove_top.sv
`timescale 1ns / 1ps
// Indexed list top: decodes the operation, clamps the position, drives the cell row.
// done_o is registered and rises in the cycle after the accepting one; throughput one item per cycle.
// On insert or remove the cell row shifts the entries from the command position upward; busy stays low.
// Reset clears the entry count and result strobe; the cell contents stay undefined.
// The receiver cannot stall: each result is shown for one cycle only.
// Depends on ilir_pkg and ilir_cell.
module indexed_list_insert_remove_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [7:0]  position_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [31:0] read_value_o,
  output logic [6:0]  count_o,
  output logic [1:0]  status_o
);

  localparam int IW = ilir_pkg::IDX_W;
  localparam int CW = ilir_pkg::CNT_W;
  localparam int PW = ilir_pkg::POS_W;
  localparam int N  = ilir_pkg::CAPACITY;

  logic [CW-1:0]   cnt_q, cnt_d;
  logic            done_q;
  logic [31:0]     rd_q, rd_d;
  logic [1:0]      st_q, st_d;
  logic            accept;
  logic            pos_neg;
  logic [PW-1:0]   pos_ext, cnt_ext;
  ilir_pkg::cmd_t  cmd;
  ilir_pkg::elem_t cell_data [N];

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign pos_neg = position_i[7];
  assign pos_ext = PW'(position_i[6:0]);
  assign cnt_ext = PW'(cnt_q);

  always_comb begin
    cmd       = '0;
    cmd.value = value_i[ilir_pkg::ELEM_WIDTH-1:0];
    cnt_d     = cnt_q;
    rd_d      = '0;
    st_d      = ilir_pkg::ST_OK;
    if (accept) begin
      case (op_i)
        ilir_pkg::OP_INSERT: begin
          if (cnt_q == CW'(N)) begin
            st_d = ilir_pkg::ST_FULL;
          end else begin
            cmd.insert = 1'b1;
            if (pos_neg) begin
              cmd.at = '0;
            end else if (pos_ext > cnt_ext) begin
              cmd.at = cnt_q[IW-1:0];
            end else begin
              cmd.at = pos_ext[IW-1:0];
            end
            cnt_d = cnt_q + CW'(1);
          end
        end
        ilir_pkg::OP_REMOVE: begin
          if (cnt_q == '0) begin
            st_d = ilir_pkg::ST_EMPTY;
          end else begin
            cmd.remove = 1'b1;
            if (pos_neg) begin
              cmd.at = '0;
            end else if (pos_ext >= cnt_ext) begin
              cmd.at = IW'(cnt_q - CW'(1));
            end else begin
              cmd.at = pos_ext[IW-1:0];
            end
            cnt_d = cnt_q - CW'(1);
          end
        end
        ilir_pkg::OP_READ: begin
          if (pos_neg || (pos_ext >= cnt_ext)) begin
            st_d = ilir_pkg::ST_RANGE;
          end else begin
            rd_d = 32'(signed'(cell_data[pos_ext[IW-1:0]]));
          end
        end
        default: begin
          st_d = ilir_pkg::ST_OK;
        end
      endcase
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    ilir_pkg::elem_t lower, upper;
    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[g-1];
    end
    if (g == N - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[g+1];
    end
    ilir_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IW'(g)),
      .cmd_i   (cmd),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= rd_d;
    st_q <= st_d;
  end

  assign done_o       = done_q;
  assign read_value_o = rd_q;
  assign count_o      = 7'(cnt_q);
  assign status_o     = st_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(N))
    else $error("entry count above capacity");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("transfer without result strobe");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result strobe without transfer");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ilir_pkg::ST_FULL) |-> (cnt_q == CW'(N)))
    else $error("full flag with room left");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i == ilir_pkg::OP_INSERT) && (cnt_q != CW'(N))
    |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("insert did not grow the list");

endmodule
